// File: sv/imheq_pkg.sv
// imheq_pkg: shared constants, types and codes for the indexed min-heap queue
// no dependencies
package imheq_pkg;

  localparam int HEAP_DEPTH   = 64;
  localparam int KEY_BITS     = 32;
  localparam int HANDLE_COUNT = 64;
  localparam int HND_W        = 6;
  localparam int POS_W        = $clog2(HEAP_DEPTH);
  localparam int CNT_W        = $clog2(HEAP_DEPTH + 1);
  localparam int SLOT_W       = HND_W + KEY_BITS;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;
  localparam logic [1:0] OP_REMOVE  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  typedef struct packed {
    logic [HND_W-1:0]    hnd;
    logic [KEY_BITS-1:0] key;
  } slot_t;

endpackage

// File: sv/imheq_ram.sv
// imheq_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
module imheq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/indexed_min_heap_eviction_queue.sv
// indexed_min_heap_eviction_queue: top level, sequencer around heap slot and position RAMs
// depends on imheq_pkg and imheq_ram; handle valid bits kept in flops
//
// channel | dir | ports                              | meaning
// in      | in  | in_valid in_ready in_op in_handle in_key | one operation beat
// out     | out | out_valid out_ready out_status out_handle out_key out_occupancy | one result
//
// one item at a time: the position map is looked up first, then each level sifted up passes
// S_URD, S_UCMP and S_PLACE and each level sifted down passes S_DRDL, S_DRDR, S_DCMP and
// S_PLACE; a rejected op goes from S_LOOK straight to S_DONE, which sets out_valid
// rst_n clears count, valid bits and control; slot and position RAMs are never cleared
// a result waits in the output register; a new beat is taken once it is gone
module indexed_min_heap_eviction_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [imheq_pkg::HND_W-1:0]    in_handle,
  input  logic [31:0]                    in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [imheq_pkg::HND_W-1:0]    out_handle,
  output logic [31:0]                    out_key,
  output logic [6:0]                     out_occupancy
);

  localparam int PW = imheq_pkg::POS_W;
  localparam int CW = imheq_pkg::CNT_W;
  localparam int KB = imheq_pkg::KEY_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROOT  = 4'd1;  // extract: read root
  localparam logic [3:0] S_LAST  = 4'd2;  // read last slot
  localparam logic [3:0] S_PLACE = 4'd3;  // write moved slot at pos
  localparam logic [3:0] S_DRDL  = 4'd4;  // down: read left child
  localparam logic [3:0] S_DRDR  = 4'd5;  // down: read right child
  localparam logic [3:0] S_DCMP  = 4'd6;  // down: decide
  localparam logic [3:0] S_URD   = 4'd7;  // up: read parent
  localparam logic [3:0] S_UCMP  = 4'd8;  // up: decide
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_ROOTW = 4'd10; // extract: root data arrives
  localparam logic [3:0] S_LOOK  = 4'd11; // position map data arrives

  logic [3:0] state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [imheq_pkg::HANDLE_COUNT-1:0] hv_r, hv_nxt;

  logic [1:0]                  op_r, op_nxt;
  logic [imheq_pkg::HND_W-1:0] hnd_r, hnd_nxt;
  logic [31:0]                 key_r, key_nxt;

  imheq_pkg::slot_t cur_r, cur_nxt;     // slot being sifted, held in flops
  imheq_pkg::slot_t lft_r, lft_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic          up_after_r, up_after_nxt;
  logic          has_r_r, has_r_nxt;

  logic [2:0]   st_r, st_nxt;
  logic [imheq_pkg::HND_W-1:0] oh_r, oh_nxt;
  logic [31:0]  ok_r, ok_nxt;
  logic         ov_r, ov_nxt;

  logic                  we;
  logic [PW-1:0]         waddr, raddr;
  imheq_pkg::slot_t      wdata, rdata;

  logic                  sof_we;
  logic [imheq_pkg::HND_W-1:0] sof_h;
  logic [PW-1:0]         sof_p;
  logic                  sof_we2;
  logic [imheq_pkg::HND_W-1:0] sof_h2;
  logic [PW-1:0]         sof_p2;
  logic                  sof_wen;
  logic [imheq_pkg::HND_W-1:0] sof_wa;
  logic [PW-1:0]         sof_wd;
  logic [PW-1:0]         sof_rdata;

  imheq_ram #(.WIDTH(imheq_pkg::SLOT_W), .DEPTH(imheq_pkg::HEAP_DEPTH)) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // position map, read at in_handle; only the read at the accepting edge, while nothing is written, is used
  imheq_ram #(.WIDTH(PW), .DEPTH(imheq_pkg::HANDLE_COUNT)) u_sof (
    .clk  (clk),
    .we   (sof_wen),
    .waddr(sof_wa),
    .wdata(sof_wd),
    .raddr(in_handle),
    .rdata(sof_rdata)
  );

  logic [CW:0]   lchild_w, rchild_w;
  logic [PW-1:0] parent_w;
  logic [PW-1:0] inpos_w;
  logic          in_acc;

  assign lchild_w = {pos_r, 1'b1};
  assign rchild_w = {pos_r, 1'b0} + {{CW{1'b0}}, 1'b1} + {{CW{1'b0}}, 1'b1};
  assign parent_w = PW'((pos_r - 1'b1) >> 1);
  assign inpos_w  = sof_rdata;
  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign in_acc   = in_valid && in_ready;

  assign sof_wen = sof_we | sof_we2;
  assign sof_wa  = sof_we2 ? sof_h2 : sof_h;
  assign sof_wd  = sof_we2 ? sof_p2 : sof_p;

  assign out_valid     = ov_r;
  assign out_status    = st_r;
  assign out_handle    = oh_r;
  assign out_key       = ok_r;
  assign out_occupancy = 7'(cnt_r);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    hv_nxt       = hv_r;
    op_nxt       = op_r;
    hnd_nxt      = hnd_r;
    key_nxt      = key_r;
    cur_nxt      = cur_r;
    lft_nxt      = lft_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    up_after_nxt = up_after_r;
    has_r_nxt    = has_r_r;
    st_nxt       = st_r;
    oh_nxt       = oh_r;
    ok_nxt       = ok_r;
    ov_nxt       = ov_r;
    we           = 1'b0;
    waddr        = pos_r;
    wdata        = cur_r;
    raddr        = pos_r;
    sof_we       = 1'b0;
    sof_h        = cur_r.hnd;
    sof_p        = pos_r;
    sof_we2      = 1'b0;
    sof_h2       = rdata.hnd;
    sof_p2       = pos_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_op;
          hnd_nxt   = in_handle;
          key_nxt   = in_key;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        st_nxt = imheq_pkg::ST_OK;
        oh_nxt = '0;
        ok_nxt = '0;
        unique case (op_r)
          imheq_pkg::OP_INSERT: begin
            if (hv_r[hnd_r]) begin
              st_nxt = imheq_pkg::ST_PRESENT;
              state_nxt = S_DONE;
            end else if (cnt_r >= CW'(imheq_pkg::HEAP_DEPTH)) begin
              st_nxt = imheq_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              hv_nxt[hnd_r] = 1'b1;
              cur_nxt.hnd = hnd_r;
              cur_nxt.key = KB'(key_r);
              pos_nxt = PW'(cnt_r);
              cnt_nxt = cnt_r + 1'b1;
              we = 1'b1;
              waddr = PW'(cnt_r);
              wdata.hnd = hnd_r;
              wdata.key = KB'(key_r);
              sof_we = 1'b1;
              sof_h = hnd_r;
              sof_p = PW'(cnt_r);
              state_nxt = S_URD;
            end
          end
          imheq_pkg::OP_EXTRACT: begin
            if (cnt_r == '0) begin
              st_nxt = imheq_pkg::ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              raddr = '0;
              state_nxt = S_ROOTW;
            end
          end
          default: begin
            if (!hv_r[hnd_r] || CW'(inpos_w) >= cnt_r) begin
              st_nxt = imheq_pkg::ST_ABSENT;
              state_nxt = S_DONE;
            end else if (op_r == imheq_pkg::OP_UPDATE) begin
              pos_nxt = inpos_w;
              start_nxt = inpos_w;
              up_after_nxt = 1'b1;
              cur_nxt.hnd = hnd_r;
              cur_nxt.key = KB'(key_r);
              we = 1'b1;
              waddr = inpos_w;
              wdata.hnd = hnd_r;
              wdata.key = KB'(key_r);
              state_nxt = S_DRDL;
            end else begin
              hv_nxt[hnd_r] = 1'b0;
              cnt_nxt = cnt_r - 1'b1;
              if (CW'(inpos_w) < cnt_r - 1'b1) begin
                pos_nxt = inpos_w;
                start_nxt = inpos_w;
                up_after_nxt = 1'b1;
                raddr = PW'(cnt_r - 1'b1);
                state_nxt = S_LAST;
              end else begin
                state_nxt = S_DONE;
              end
            end
          end
        endcase
      end
      S_ROOTW: begin
        oh_nxt = rdata.hnd;
        ok_nxt = 32'(rdata.key);
        hv_nxt[rdata.hnd] = 1'b0;
        cnt_nxt = cnt_r - 1'b1;
        pos_nxt = '0;
        start_nxt = '0;
        up_after_nxt = 1'b0;
        if (cnt_r > CW'(1)) begin
          raddr = PW'(cnt_r - 1'b1);
          state_nxt = S_LAST;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LAST: begin
        cur_nxt = rdata;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        we = 1'b1;
        sof_we = 1'b1;
        state_nxt = S_DRDL;
      end
      S_DRDL: begin
        if (CW'(lchild_w) < cnt_r && lchild_w <= (CW + 1)'(imheq_pkg::HEAP_DEPTH - 1)) begin
          raddr = PW'(lchild_w);
          state_nxt = S_DRDR;
        end else begin
          pos_nxt = start_r;
          state_nxt = up_after_r ? S_URD : S_DONE;
        end
      end
      S_DRDR: begin
        lft_nxt = rdata;
        has_r_nxt = (rchild_w < (CW + 1)'(cnt_r));
        raddr = PW'(rchild_w);
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        if (has_r_r && rdata.key < cur_r.key && !(lft_r.key < cur_r.key
            && !(rdata.key < lft_r.key))) begin
          we = 1'b1;
          wdata = rdata;
          sof_we2 = 1'b1;
          sof_h2 = rdata.hnd;
          pos_nxt = PW'(rchild_w);
          state_nxt = S_PLACE;
        end else if (lft_r.key < cur_r.key) begin
          we = 1'b1;
          wdata = lft_r;
          sof_we2 = 1'b1;
          sof_h2 = lft_r.hnd;
          pos_nxt = PW'(lchild_w);
          state_nxt = S_PLACE;
        end else begin
          pos_nxt = start_r;
          state_nxt = up_after_r ? S_URD : S_DONE;
        end
      end
      S_URD: begin
        if (pos_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          raddr = parent_w;
          state_nxt = S_UCMP;
        end
      end
      S_UCMP: begin
        if (rdata.key <= cur_r.key) begin
          state_nxt = S_DONE;
        end else begin
          we = 1'b1;
          waddr = pos_r;
          wdata = rdata;
          sof_we2 = 1'b1;
          sof_h2 = rdata.hnd;
          sof_p2 = pos_r;
          pos_nxt = parent_w;
          state_nxt = S_PLACE;
          up_after_nxt = 1'b0;
          start_nxt = parent_w;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // after an up move the next visit to S_PLACE continues upward
  logic going_up_r, going_up_nxt;
  always_comb begin
    going_up_nxt = going_up_r;
    if (state_r == S_IDLE) begin
      going_up_nxt = 1'b0;
    end else if (state_r == S_UCMP) begin
      going_up_nxt = 1'b1;
    end
  end

  logic [3:0] state_fix;
  always_comb begin
    state_fix = state_nxt;
    if (state_r == S_PLACE && going_up_r) begin
      state_fix = S_URD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      hv_r       <= '0;
      ov_r       <= 1'b0;
      going_up_r <= 1'b0;
    end else begin
      state_r    <= state_fix;
      cnt_r      <= cnt_nxt;
      hv_r       <= hv_nxt;
      ov_r       <= ov_nxt;
      going_up_r <= going_up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    hnd_r      <= hnd_nxt;
    key_r      <= key_nxt;
    cur_r      <= cur_nxt;
    lft_r      <= lft_nxt;
    pos_r      <= pos_nxt;
    start_r    <= start_nxt;
    up_after_r <= up_after_nxt;
    has_r_r    <= has_r_nxt;
    st_r       <= st_nxt;
    oh_r       <= oh_nxt;
    ok_r       <= ok_nxt;
  end

endmodule

// File: sim/tb.sv
// tb: self-checking testbench for indexed_min_heap_eviction_queue
// depends on imheq_pkg and the heap queue RTL; keeps its own indexed heap predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  hnd;
    logic [31:0] key;
  } op_beat_t;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  hnd;
    logic [31:0] key;
    logic [6:0]  occ;
  } heap_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic [5:0] in_handle = '0;
  logic [31:0] in_key = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] out_status;
  logic [5:0] out_handle;
  logic [31:0] out_key;
  logic [6:0] out_occupancy;

  op_beat_t pending_ops[$];
  heap_result_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 69;
  bit hold_off = 0;
  int hold_cnt = 0;
  longint cycle_cnt = 0;
  bit stim_done = 0;
  bit in_ready_seen = 0;

  logic [5:0]  ph_hnd[imheq_pkg::HEAP_DEPTH];
  logic [31:0] ph_key[imheq_pkg::HEAP_DEPTH];
  int          pos_of[imheq_pkg::HANDLE_COUNT];
  bit          present[imheq_pkg::HANDLE_COUNT];
  int          count;

  indexed_min_heap_eviction_queue DUT (.*);

  always #5 clk = ~clk;

  function automatic void place(int p, logic [5:0] h, logic [31:0] k);
    ph_hnd[p] = h;
    ph_key[p] = k;
    pos_of[h] = p;
  endfunction

  function automatic void swap_pos(int a, int b);
    logic [5:0] h;
    logic [31:0] k;
    h = ph_hnd[a];
    k = ph_key[a];
    place(a, ph_hnd[b], ph_key[b]);
    place(b, h, k);
  endfunction

  function automatic void bubble_up(int p);
    int par;
    while (p > 0 && p < count) begin
      par = (p - 1) / 2;
      if (ph_key[par] <= ph_key[p]) break;
      swap_pos(par, p);
      p = par;
    end
  endfunction

  function automatic void bubble_down(int p);
    int best, l, r;
    while (p < count) begin
      best = p;
      l = 2 * p + 1;
      r = 2 * p + 2;
      if (l < count && ph_key[l] < ph_key[best]) best = l;
      if (r < count && ph_key[r] < ph_key[best]) best = r;
      if (best == p) break;
      swap_pos(p, best);
      p = best;
    end
  endfunction

  function automatic heap_result_t apply_heap_op(op_beat_t b);
    heap_result_t res;
    int p;
    res = '{imheq_pkg::ST_OK, '0, '0, '0};
    case (b.op)
      imheq_pkg::OP_INSERT: begin
        if (present[b.hnd]) res.status = imheq_pkg::ST_PRESENT;
        else if (count >= imheq_pkg::HEAP_DEPTH) res.status = imheq_pkg::ST_FULL;
        else begin
          present[b.hnd] = 1;
          place(count, b.hnd, b.key);
          count++;
          bubble_up(count - 1);
        end
      end
      imheq_pkg::OP_EXTRACT: begin
        if (count == 0) res.status = imheq_pkg::ST_EMPTY;
        else begin
          res.hnd = ph_hnd[0];
          res.key = ph_key[0];
          present[ph_hnd[0]] = 0;
          count--;
          if (count > 0) begin
            place(0, ph_hnd[count], ph_key[count]);
            bubble_down(0);
          end
        end
      end
      default: begin
        p = pos_of[b.hnd];
        if (!present[b.hnd] || p >= count) res.status = imheq_pkg::ST_ABSENT;
        else if (b.op == imheq_pkg::OP_UPDATE) begin
          ph_key[p] = b.key;
          bubble_down(p);
          bubble_up(p);
        end else begin
          present[b.hnd] = 0;
          count--;
          if (p < count) begin
            place(p, ph_hnd[count], ph_key[count]);
            bubble_down(p);
            bubble_up(p);
          end
        end
      end
    endcase
    res.occ = count[6:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic push(logic [1:0] op, logic [5:0] h, logic [31:0] k);
    pending_ops.push_back('{op, h, k});
  endtask

  task automatic wait_drain();
    while (pending_ops.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          op_beat_t b;
          b = pending_ops.pop_front();
          in_valid <= 1;
          in_op <= b.op;
          in_handle <= b.hnd;
          in_key <= b.key;
        end else begin
          in_valid <= 0;
        end
      end
      out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    in_ready_seen <= 0;
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(apply_heap_op('{in_op, in_handle, in_key}));
      in_ready_seen <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_handle !== e.hnd) begin
          $error("out_handle exp %0d got %0d", e.hnd, out_handle); errors++;
        end
        if (out_key !== e.key) begin
          $error("out_key exp %h got %h", e.key, out_key); errors++;
        end
        if (out_occupancy !== e.occ) begin
          $error("out_occupancy exp %0d got %0d", e.occ, out_occupancy); errors++;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 300) hold_off <= 0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    for (int i = 0; i < imheq_pkg::HANDLE_COUNT; i++) begin
      present[i] = 0;
      pos_of[i] = 0;
    end
    count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: empty, absent, extremes, ties, duplicate, remove last slot
    push(imheq_pkg::OP_EXTRACT, 6'd0, 32'h0);
    push(imheq_pkg::OP_UPDATE, 6'd5, 32'h1);
    push(imheq_pkg::OP_REMOVE, 6'd63, 32'h0);
    push(imheq_pkg::OP_INSERT, 6'd0, 32'hFFFF_FFFF);
    push(imheq_pkg::OP_INSERT, 6'd63, 32'h0);
    push(imheq_pkg::OP_INSERT, 6'd7, 32'h0);
    push(imheq_pkg::OP_INSERT, 6'd7, 32'h5);
    push(imheq_pkg::OP_INSERT, 6'd21, 32'h8000_0000);
    push(imheq_pkg::OP_UPDATE, 6'd63, 32'hFFFF_FFFF);
    push(imheq_pkg::OP_UPDATE, 6'd0, 32'h0);
    push(imheq_pkg::OP_REMOVE, 6'd21, 32'h0);
    push(imheq_pkg::OP_REMOVE, 6'd7, 32'h0);
    push(imheq_pkg::OP_EXTRACT, 6'd0, 32'h0);
    push(imheq_pkg::OP_EXTRACT, 6'd0, 32'h0);
    push(imheq_pkg::OP_EXTRACT, 6'd0, 32'h0);
    wait_drain();

    // fill to full, then a duplicate insert on a full heap
    for (int i = 0; i < imheq_pkg::HANDLE_COUNT; i++)
      push(imheq_pkg::OP_INSERT, 6'(i), $urandom_range(0, 7));
    push(imheq_pkg::OP_INSERT, 6'd12, 32'h3);
    hold_off = 1;
    hold_cnt = 0;
    wait_drain();
    for (int i = 0; i < 64; i++) push(imheq_pkg::OP_EXTRACT, 6'($urandom), $urandom);
    push(imheq_pkg::OP_EXTRACT, 6'd0, 32'h0);
    wait_drain();

    // random, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 10 : 0;
      n = 0;
      while (n < 420) begin
        if ($urandom_range(0, 9) == 0) begin
          push(2'($urandom), 6'($urandom), $urandom);
        end else begin
          // mostly well-formed traffic sized toward a well-filled heap
          case ($urandom_range(0, 9))
            0, 1, 2, 3: push(imheq_pkg::OP_INSERT, 6'($urandom), rand_key());
            4, 5: push(imheq_pkg::OP_EXTRACT, 6'($urandom), $urandom);
            6, 7: push(imheq_pkg::OP_UPDATE, 6'($urandom), rand_key());
            default: push(imheq_pkg::OP_REMOVE, 6'($urandom), $urandom);
          endcase
        end
        n++;
      end
      wait_drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// File: indexed_min_heap_eviction_queue.f
sv/imheq_pkg.sv
sv/imheq_ram.sv
sv/indexed_min_heap_eviction_queue.sv
sim/tb.sv
